FILE: src/wsfd_pkg.sv
// Package with the parser phases, header constants and result type of the frame decoder.
`timescale 1ns / 1ps

package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_COUNT = 3'd1;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] KEY_COUNT   = 3'd3;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        logic       is_first;
        logic       is_last;
        logic       is_empty;
    } t_result;

endpackage

FILE: src/wsfd_in_if.sv
// Stream interface that carries received bytes into the frame decoder.
`timescale 1ns / 1ps

interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/wsfd_out_if.sv
// Stream interface that carries decoded payload results out of the frame decoder.
`timescale 1ns / 1ps

interface wsfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       is_first;
    logic       is_last;
    logic       is_empty;

    modport source (
        output valid, output payload_byte, output frame_opcode, output frame_fin,
        output is_first, output is_last, output is_empty, input ready
    );
    modport sink (
        input valid, input payload_byte, input frame_opcode, input frame_fin,
        input is_first, input is_last, input is_empty, output ready
    );
endinterface

FILE: src/websocket_frame_decoder.sv
// Top level of the streaming WebSocket frame decoder.
//
// Received bytes enter on i_rx, one per transaction, and frames may follow each
// other with no gap. Header bytes give no result. Each payload byte leaves on
// o_res unmasked, with the frame's opcode and FIN and first/last flags; a frame
// with an empty payload gives one marker result with is_empty set.
// Each byte is held in an input register and parsed into the result register,
// from which its result is offered on o_res. One byte is accepted every cycle
// while o_res does not stall; the single parse stage with its 64-bit length
// decrement sets that figure.
// When o_res stalls, the result register holds its transaction, the byte in
// the input register waits if it would give a result, and i_rx ready then drops.
// Bytes that give no result keep moving while the result register is full.
// Reset is synchronous and active low: both registers empty and the parser
// waits for the first header byte of a new frame.
`timescale 1ns / 1ps

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfd_in_if.sink     i_rx,
    wsfd_out_if.source  o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ext_count, n_ext_count;
    logic [63:0] r_remaining_len, n_remaining_len;
    logic [1:0]  r_pos, n_pos;
    logic        r_first, n_first;
    logic [31:0] r_mask_key, n_mask_key;
    logic        r_mask_on, n_mask_on;
    logic [3:0]  r_cur_opcode, n_cur_opcode;
    logic        r_cur_fin, n_cur_fin;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        n_produce;

    logic        hdr_done;
    logic [63:0] hdr_len;
    logic        out_free;
    logic        stage_fire;
    logic [7:0]  key_byte;

    assign out_free   = !r_out_valid || o_res.ready;
    assign stage_fire = r_in_valid && (!n_produce || out_free);
    assign i_rx.ready = !r_in_valid || stage_fire;

    always_comb begin
        unique case (r_pos)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    // Detects the last header byte of a frame and the payload length it leaves.
    always_comb begin
        hdr_done = 1'b0;
        hdr_len  = r_remaining_len;
        unique case (r_phase)
            PH_HDR1: begin
                hdr_len  = {57'd0, r_in_byte[6:0]};
                hdr_done = (r_in_byte[6:0] != LEN_EXT16) && (r_in_byte[6:0] != LEN_EXT64)
                           && !r_in_byte[7];
            end
            PH_EXT: begin
                hdr_len  = {r_remaining_len[55:0], r_in_byte};
                hdr_done = (r_ext_count == 3'd0) && !r_mask_on;
            end
            PH_KEY: begin
                hdr_done = (r_ext_count == 3'd0);
            end
            default: begin
                hdr_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HDR1: begin
                if (r_in_byte[6:0] == LEN_EXT16 || r_in_byte[6:0] == LEN_EXT64) begin
                    n_phase = PH_EXT;
                end else if (r_in_byte[7]) begin
                    n_phase = PH_KEY;
                end
            end
            PH_EXT: begin
                if (r_ext_count == 3'd0 && r_mask_on) begin
                    n_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                n_phase = r_phase;
            end
            PH_DATA: begin
                if (r_remaining_len == 64'd1) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HDR1;
            end
        endcase
        if (hdr_done) begin
            n_phase = (hdr_len == 64'd0) ? PH_HDR0 : PH_DATA;
        end
    end

    always_comb begin
        n_ext_count     = r_ext_count;
        n_remaining_len = r_remaining_len;
        n_pos           = r_pos;
        n_first         = r_first;
        n_mask_key      = r_mask_key;
        n_mask_on       = r_mask_on;
        n_cur_opcode    = r_cur_opcode;
        n_cur_fin       = r_cur_fin;
        n_produce       = 1'b0;
        n_out.payload_byte = 8'd0;
        n_out.frame_opcode = r_cur_opcode;
        n_out.frame_fin    = r_cur_fin;
        n_out.is_first     = 1'b1;
        n_out.is_last      = 1'b1;
        n_out.is_empty     = 1'b1;
        unique case (r_phase)
            PH_HDR1: begin
                n_mask_on       = r_in_byte[7];
                n_mask_key      = 32'd0;
                n_remaining_len = hdr_len;
                if (r_in_byte[6:0] == LEN_EXT16) begin
                    n_remaining_len = 64'd0;
                    n_ext_count     = EXT16_COUNT;
                end else if (r_in_byte[6:0] == LEN_EXT64) begin
                    n_remaining_len = 64'd0;
                    n_ext_count     = EXT64_COUNT;
                end else if (r_in_byte[7]) begin
                    n_ext_count = KEY_COUNT;
                end
            end
            PH_EXT: begin
                n_remaining_len = hdr_len;
                if (r_ext_count != 3'd0) begin
                    n_ext_count = r_ext_count - 3'd1;
                end else if (r_mask_on) begin
                    n_ext_count = KEY_COUNT;
                end
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], r_in_byte};
                if (r_ext_count != 3'd0) begin
                    n_ext_count = r_ext_count - 3'd1;
                end
            end
            PH_DATA: begin
                n_produce          = 1'b1;
                n_out.payload_byte = r_mask_on ? (r_in_byte ^ key_byte) : r_in_byte;
                n_out.is_first     = r_first;
                n_out.is_last      = (r_remaining_len == 64'd1);
                n_out.is_empty     = 1'b0;
                n_pos              = r_pos + 2'd1;
                n_first            = 1'b0;
                n_remaining_len    = r_remaining_len - 64'd1;
            end
            default: begin
                n_cur_fin    = r_in_byte[7];
                n_cur_opcode = r_in_byte[3:0];
            end
        endcase
        if (hdr_done) begin
            n_pos     = 2'd0;
            n_first   = 1'b1;
            n_produce = (hdr_len == 64'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HDR0;
            r_ext_count     <= 3'd0;
            r_remaining_len <= 64'd0;
            r_pos           <= 2'd0;
            r_first         <= 1'b1;
            r_mask_key      <= 32'd0;
            r_mask_on       <= 1'b0;
            r_cur_opcode    <= 4'd0;
            r_cur_fin       <= 1'b0;
        end else if (stage_fire) begin
            r_phase         <= n_phase;
            r_ext_count     <= n_ext_count;
            r_remaining_len <= n_remaining_len;
            r_pos           <= n_pos;
            r_first         <= n_first;
            r_mask_key      <= n_mask_key;
            r_mask_on       <= n_mask_on;
            r_cur_opcode    <= n_cur_opcode;
            r_cur_fin       <= n_cur_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && n_produce) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && n_produce) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.frame_opcode = r_out.frame_opcode;
    assign o_res.frame_fin    = r_out.frame_fin;
    assign o_res.is_first     = r_out.is_first;
    assign o_res.is_last      = r_out.is_last;
    assign o_res.is_empty     = r_out.is_empty;

endmodule
